### hw/rtl/lcsp_pkg.sv
// ----------------------------------------------------------------------------
// lcsp_pkg
// Shared types, constants and helpers of the load-cell stability block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsp_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 10;
  localparam int WEIGHT_FRAC_BITS     = 8;
  localparam int CAL_SHIFT            = 24 - WEIGHT_FRAC_BITS;
  localparam int QUEUE_DEPTH          = 2;
  localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W              = 5;

  localparam logic [2:0] REG_TARE   = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_ALPHA  = 3'd2;
  localparam logic [2:0] REG_RANGE  = 3'd3;
  localparam logic [2:0] REG_SETTLE = 3'd4;
  localparam logic [2:0] REG_ABSENT = 3'd5;

  localparam logic signed [24:0] TARE_RESET   = 25'sd51233;
  localparam logic [19:0]        GAIN_RESET   = 20'd40113;
  localparam logic [8:0]         ALPHA_RESET  = 9'd77;
  localparam logic [8:0]         ALPHA_MAX    = 9'd256;
  localparam logic [23:0]        RANGE_RESET  = 24'd768;
  localparam logic [7:0]         SETTLE_RESET = 8'd30;
  localparam logic signed [23:0] ABSENT_RESET = -24'sd2560;

  localparam logic [7:0] RUN_MAX = 8'd255;

  localparam logic [2:0] PRES_INITIAL   = 3'd0;
  localparam logic [2:0] PRES_ABSENT    = 3'd1;
  localparam logic [2:0] PRES_RECOVER   = 3'd2;
  localparam logic [2:0] PRES_STABLE    = 3'd3;
  localparam logic [2:0] PRES_UNSTABLE  = 3'd4;

  localparam logic signed [47:0] W24_MAX = 48'sd8388607;
  localparam logic signed [47:0] W24_MIN = -48'sd8388608;

  typedef struct packed {
    logic signed [24:0] tare;
    logic [19:0]        gain;
    logic [8:0]         alpha;
    logic [23:0]        range;
    logic [7:0]         settle;
    logic signed [23:0] absent;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] raw_sample;
    logic               sample_ready;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] weight_q8;
    logic [23:0]        window_spread_q8;
    logic               stable_flag;
    logic [2:0]         presence_state;
    logic               save_event;
    logic               report_event;
  } result_t;

  typedef struct packed {
    logic signed [23:0] weight;
    logic               ready;
  } cal_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [23:0] sat_w24(input logic signed [47:0] x);
    logic signed [23:0] r;
    if (x > W24_MAX) begin
      r = 24'sh7FFFFF;
    end else if (x < W24_MIN) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/load_cell_stability_presence.sv
// ----------------------------------------------------------------------------
// load_cell_stability_presence
// Load-cell calibration, smoothing, stability window and presence tracking.
// ----------------------------------------------------------------------------
//  channel   valid          stall          payload
//  sample    sample_valid   sample_stall   sample (sample_t)
//  result    result_valid   result_stall   result (result_t)
//  config    APB write/read, pready tied high
//
//  Front steps per beat: add, gain multiply, queue push.
//  Back steps: delta, alpha multiply, update, serial window scan, evaluate.
//  The first beat after reset seeds the filter and window, skipping the scan.
//  Reset is synchronous; a two-entry queue lets the front take beats while
//  a result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_stability_presence #(
  parameter int WINDOW_DEPTH = lcsp_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output      logic                         sample_stall,
  input  wire lcsp_pkg::sample_t            sample,
  output      logic                         result_valid,
  input  wire logic                         result_stall,
  output      lcsp_pkg::result_t            result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lcsp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  lcsp_pkg::cfg_t      cfg;
  lcsp_pkg::cal_t      push_data;
  lcsp_pkg::cal_t      head;
  lcsp_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;

  lcsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg          (cfg),
    .q_full       (q_status.full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  lcsp_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (push_data),
    .pop    (q_pop),
    .rdata  (head),
    .status (q_status)
  );

  lcsp_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_status.empty),
    .q_data       (head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_report_saves: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.report_event |->
      result.save_event && result.presence_state == lcsp_pkg::PRES_STABLE)
    else $error("report without save into stable");

  a_stable_flagged: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.presence_state == lcsp_pkg::PRES_STABLE |->
      result.stable_flag)
    else $error("stable presence without stable flag");

endmodule

`default_nettype wire

### hw/rtl/lcsp_regs.sv
// ----------------------------------------------------------------------------
// lcsp_regs
// APB register file holding calibration, filter and presence settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsp_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lcsp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready,
  output      lcsp_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tare   <= lcsp_pkg::TARE_RESET;
      cfg.gain   <= lcsp_pkg::GAIN_RESET;
      cfg.alpha  <= lcsp_pkg::ALPHA_RESET;
      cfg.range  <= lcsp_pkg::RANGE_RESET;
      cfg.settle <= lcsp_pkg::SETTLE_RESET;
      cfg.absent <= lcsp_pkg::ABSENT_RESET;
    end else if (wr_en) begin
      case (idx)
        lcsp_pkg::REG_TARE:   cfg.tare   <= pwdata[24:0];
        lcsp_pkg::REG_GAIN:   cfg.gain   <= pwdata[19:0];
        lcsp_pkg::REG_ALPHA:  cfg.alpha  <= pwdata[8:0];
        lcsp_pkg::REG_RANGE:  cfg.range  <= pwdata[23:0];
        lcsp_pkg::REG_SETTLE: cfg.settle <= pwdata[7:0];
        lcsp_pkg::REG_ABSENT: cfg.absent <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lcsp_pkg::REG_TARE:   prdata = 32'(cfg.tare);
      lcsp_pkg::REG_GAIN:   prdata = 32'(cfg.gain);
      lcsp_pkg::REG_ALPHA:  prdata = 32'(cfg.alpha);
      lcsp_pkg::REG_RANGE:  prdata = 32'(cfg.range);
      lcsp_pkg::REG_SETTLE: prdata = 32'(cfg.settle);
      lcsp_pkg::REG_ABSENT: prdata = 32'(cfg.absent);
      default:              prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/lcsp_front.sv
// ----------------------------------------------------------------------------
// lcsp_front
// Accepts sample beats, applies tare and gain, and queues calibrated weights.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output      logic                sample_stall,
  input  wire lcsp_pkg::sample_t   sample,
  input  wire lcsp_pkg::cfg_t      cfg,
  input  wire logic                q_full,
  output      logic                q_push,
  output      lcsp_pkg::cal_t      q_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t       state;
  logic signed [25:0] sum;
  logic signed [46:0] prod;
  logic               rdy;

  assign sample_stall = (state != F_IDLE);
  assign q_push       = (state == F_PUSH) && !q_full;
  assign q_data.ready  = rdy;
  assign q_data.weight = lcsp_pkg::sat_w24(48'(prod >>> lcsp_pkg::CAL_SHIFT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (sample_valid) state <= F_MUL;
        F_MUL:  state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && sample_valid) begin
      sum <= 26'(sample.raw_sample) + 26'(cfg.tare);
      rdy <= sample.sample_ready;
    end
    if (state == F_MUL) begin
      prod <= sum * $signed({1'b0, cfg.gain});
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcsp_fifo.sv
// ----------------------------------------------------------------------------
// lcsp_fifo
// Short queue of calibrated weights between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsp_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lcsp_pkg::cal_t      wdata,
  input  wire logic                pop,
  output      lcsp_pkg::cal_t      rdata,
  output      lcsp_pkg::q_status_t status
);

  localparam int PW = lcsp_pkg::QUEUE_PTR_W;
  localparam int CW = lcsp_pkg::QUEUE_CNT_W;

  lcsp_pkg::cal_t mem [lcsp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign status.full  = (count == CW'(lcsp_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(lcsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(lcsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcsp_back.sv
// ----------------------------------------------------------------------------
// lcsp_back
// Filters queued weights, scans the window and runs the presence machine.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsp_back #(
  parameter int WINDOW_DEPTH = lcsp_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lcsp_pkg::cfg_t    cfg,
  input  wire logic              q_empty,
  input  wire lcsp_pkg::cal_t    q_data,
  output      logic              q_pop,
  output      logic              result_valid,
  input  wire logic              result_stall,
  output      lcsp_pkg::result_t result
);

  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_UPD  = 5'b00100,
    B_SCAN = 5'b01000,
    B_EVAL = 5'b10000
  } back_state_t;

  typedef enum logic [4:0] {
    P_INITIAL  = 5'b00001,
    P_ABSENT   = 5'b00010,
    P_RECOVER  = 5'b00100,
    P_STABLE   = 5'b01000,
    P_UNSTABLE = 5'b10000
  } pres_t;

  back_state_t        state;
  pres_t              presence;
  pres_t              presence_next;
  logic               seeded;
  logic               seed_tick;
  logic [7:0]         steady_run;
  logic [7:0]         steady_run_next;
  logic [SW-1:0]      write_slot;
  logic [SW-1:0]      scan_idx;
  logic signed [23:0] filtered;
  logic signed [23:0] window [WINDOW_DEPTH];
  logic signed [23:0] mn;
  logic signed [23:0] mx;
  logic signed [24:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] prod_round;
  logic signed [23:0] f_upd;
  logic signed [23:0] s_sel;
  logic signed [23:0] w_scan;
  logic signed [24:0] spread_full;
  logic [23:0]        spread;
  logic [8:0]         alpha_sat;
  logic               flag;
  logic               save;
  logic               report;
  logic               out_free;
  logic               emit;

  function automatic logic [2:0] pres_code(input pres_t p);
    logic [2:0] c;
    case (p)
      P_ABSENT:   c = lcsp_pkg::PRES_ABSENT;
      P_RECOVER:  c = lcsp_pkg::PRES_RECOVER;
      P_STABLE:   c = lcsp_pkg::PRES_STABLE;
      P_UNSTABLE: c = lcsp_pkg::PRES_UNSTABLE;
      default:    c = lcsp_pkg::PRES_INITIAL;
    endcase
    return c;
  endfunction

  assign q_pop      = (state == B_IDLE) && !q_empty;
  assign out_free   = !result_valid || !result_stall;
  assign emit       = (state == B_EVAL) && out_free;
  assign alpha_sat  = (cfg.alpha > lcsp_pkg::ALPHA_MAX) ? lcsp_pkg::ALPHA_MAX : cfg.alpha;
  assign s_sel      = q_data.ready ? q_data.weight : filtered;
  assign prod_round = prod + 35'sd128;
  assign f_upd      = lcsp_pkg::sat_w24(48'(filtered) + 48'(prod_round >>> 8));
  assign w_scan     = window[scan_idx];
  assign spread_full = 25'(mx) - 25'(mn);
  assign spread      = spread_full[23:0];

  always_comb begin
    if (spread < cfg.range) begin
      steady_run_next = (steady_run == lcsp_pkg::RUN_MAX) ? steady_run : steady_run + 8'd1;
    end else begin
      steady_run_next = 8'd0;
    end
    flag          = (steady_run_next >= cfg.settle);
    presence_next = presence;
    save          = 1'b0;
    report        = 1'b0;
    if (filtered < cfg.absent) begin
      save          = (presence == P_STABLE);
      presence_next = P_ABSENT;
    end else begin
      case (presence)
        P_ABSENT: presence_next = P_RECOVER;
        P_RECOVER, P_UNSTABLE: begin
          if (flag) begin
            presence_next = P_STABLE;
            save          = 1'b1;
            report        = 1'b1;
          end
        end
        P_STABLE: if (!flag) presence_next = P_UNSTABLE;
        default: begin
          if (flag) begin
            presence_next = P_STABLE;
            save          = 1'b1;
          end else begin
            presence_next = P_UNSTABLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      presence     <= P_INITIAL;
      seeded       <= 1'b0;
      seed_tick    <= 1'b0;
      steady_run   <= 8'd0;
      write_slot   <= '0;
      scan_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (!seeded) begin
              seeded     <= 1'b1;
              seed_tick  <= 1'b1;
              write_slot <= '0;
              state      <= B_EVAL;
            end else begin
              state <= B_MUL;
            end
          end
        end
        B_MUL: state <= B_UPD;
        B_UPD: begin
          write_slot <= (write_slot == SW'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
          scan_idx   <= '0;
          state      <= B_SCAN;
        end
        B_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == SW'(WINDOW_DEPTH - 1)) state <= B_EVAL;
        end
        B_EVAL: begin
          if (out_free) begin
            seed_tick <= 1'b0;
            if (!seed_tick) begin
              steady_run <= steady_run_next;
              presence   <= presence_next;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      if (!seeded) begin
        filtered <= q_data.ready ? q_data.weight : 24'sd0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          window[i] <= q_data.ready ? q_data.weight : 24'sd0;
        end
      end else begin
        diff <= 25'(s_sel) - 25'(filtered);
      end
    end
    if (state == B_MUL) begin
      prod <= diff * $signed({1'b0, alpha_sat});
    end
    if (state == B_UPD) begin
      filtered           <= f_upd;
      window[write_slot] <= f_upd;
    end
    if (state == B_SCAN) begin
      if (scan_idx == '0 || w_scan < mn) mn <= w_scan;
      if (scan_idx == '0 || w_scan > mx) mx <= w_scan;
    end
    if (emit) begin
      result.weight_q8 <= filtered;
      if (seed_tick) begin
        result.window_spread_q8 <= 24'd0;
        result.stable_flag      <= 1'b0;
        result.presence_state   <= pres_code(presence);
        result.save_event       <= 1'b0;
        result.report_event     <= 1'b0;
      end else begin
        result.window_spread_q8 <= spread;
        result.stable_flag      <= flag;
        result.presence_state   <= pres_code(presence_next);
        result.save_event       <= save;
        result.report_event     <= report;
      end
    end
  end

endmodule

`default_nettype wire
